FILE: sv/ssr_pkg.sv
// Shared types and constants for the switch slew ramp block.
// No dependencies; imported by switch_slew_ramp and its checker.
package ssr_pkg;

	localparam int DUR_W = 14;
	localparam int VAL_W = 10;
	localparam int QUO_W = 10;
	localparam int REM_W = DUR_W + 1;
	localparam int CNT_W = 4;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

	localparam logic [VAL_W-1:0] VAL_ZERO = 10'h000;
	localparam logic [VAL_W-1:0] VAL_POS_FULL = 10'h100;
	localparam logic [VAL_W-1:0] VAL_NEG_FULL = 10'h300;
	localparam logic [VAL_W-1:0] VAL_OFFSET = 10'h100;

	localparam logic REG_RAMP_DURATION = 1'b0;

	typedef enum logic [1:0] {
		SW_DISCONNECTED = 2'd0,
		SW_DOWN = 2'd1,
		SW_CENTER = 2'd2,
		SW_UP = 2'd3
	} switch_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_WAIT
	} state_t;

endpackage

FILE: sv/switch_slew_ramp.sv
// Slew-rate limited three-position switch to normalized analog value.
// Uses ssr_pkg; one shared restoring divider step under a small sequencer.
//
// channel | handshake                       | payload
// req     | req_valid / req_ready           | switch_state, now_ms
// rsp     | rsp_valid / rsp_ready           | value
// cfg     | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// A ramping request: the accept edge moves the position, ten divider steps
// follow (one quotient bit each), then the wait state loads the output once
// the output register is free.
// Disconnected and snapping requests skip the divider and go straight to the wait state.
// A new request is taken once the previous one sits in the output register.
// Reset clears state, position, stamp and duration; position starts unset.
module switch_slew_ramp
	import ssr_pkg::*;
#(
	parameter int TIME_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        switch_state,
	input  logic [15:0]       now_ms,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic signed [VAL_W-1:0] value,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int WB = ((TIME_BITS > DUR_W) ? TIME_BITS : DUR_W) + 2;

	state_t state_q, state_d;

	logic [DUR_W-1:0]     duration_q;
	logic                 unset_q;
	logic [DUR_W-1:0]     position_q;
	logic [TIME_BITS-1:0] stamp_q;
	logic [REM_W-1:0]     rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [VAL_W-1:0]     res_q;
	logic                 rsp_valid_q;
	logic [VAL_W-1:0]     value_q;

	logic                 cfg_write;
	logic                 accept;
	logic                 load_out;
	logic                 div_done;
	switch_t              sw;
	logic [DUR_W-1:0]     target;
	logic [VAL_W-1:0]     snap_val;
	logic                 snap;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] delta;
	logic [WB-1:0]        pos_ext, tgt_ext, del_ext;
	logic [WB-1:0]        up_sum, dn_lim, dn_dif, moved_ext;
	logic [DUR_W-1:0]     moved;
	logic [REM_W-1:0]     dur_ext;
	logic                 qbit;
	logic [REM_W-1:0]     rem_sub;
	logic [REM_W-1:0]     rem_next;
	logic [QUO_W-1:0]     quo_next;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata = (paddr[ADDR_W-1] == REG_RAMP_DURATION) ?
		DATA_W'(duration_q) : '0;

	// target and snap selection
	assign sw = switch_t'(switch_state);
	always_comb begin
		unique case (sw)
			SW_UP: begin
				target = duration_q;
				snap_val = VAL_POS_FULL;
			end
			SW_CENTER: begin
				target = duration_q >> 1;
				snap_val = VAL_ZERO;
			end
			SW_DOWN: begin
				target = '0;
				snap_val = VAL_NEG_FULL;
			end
			default: begin
				target = '0;
				snap_val = VAL_ZERO;
			end
		endcase
	end
	assign snap = (duration_q == '0) || unset_q;

	// slew step: move toward target by elapsed time, stop at target
	assign now_t = TIME_BITS'(now_ms);
	assign delta = now_t - stamp_q;
	assign pos_ext = WB'(position_q);
	assign tgt_ext = WB'(target);
	assign del_ext = WB'(delta);
	assign up_sum = pos_ext + del_ext;
	assign dn_lim = tgt_ext + del_ext;
	assign dn_dif = pos_ext - del_ext;
	always_comb begin
		priority if (pos_ext < tgt_ext) begin
			moved_ext = (up_sum > tgt_ext) ? tgt_ext : up_sum;
		end else if (pos_ext < dn_lim) begin
			moved_ext = tgt_ext;
		end else begin
			moved_ext = dn_dif;
		end
	end
	assign moved = moved_ext[DUR_W-1:0];

	// restoring divider step
	assign dur_ext = REM_W'(duration_q);
	assign qbit = rem_q >= dur_ext;
	assign rem_sub = qbit ? (rem_q - dur_ext) : rem_q;
	assign rem_next = {rem_sub[REM_W-2:0], 1'b0};
	assign quo_next = {quo_q[QUO_W-2:0], qbit};
	assign div_done = cnt_q == DIV_LAST;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (sw == SW_DISCONNECTED || snap) begin
						state_d = ST_WAIT;
					end else begin
						state_d = ST_CALC;
					end
				end
			end
			ST_CALC: begin
				if (div_done) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_ready = state_q == ST_IDLE;
		load_out = (state_q == ST_WAIT) && (!rsp_valid_q || rsp_ready);
	end
	assign accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q <= '0;
			unset_q <= 1'b1;
			position_q <= '0;
			stamp_q <= '0;
			rsp_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cfg_write && paddr[ADDR_W-1] == REG_RAMP_DURATION) begin
				duration_q <= pwdata[DUR_W-1:0];
				unset_q <= 1'b1;
			end
			if (accept && sw != SW_DISCONNECTED) begin
				if (snap) begin
					position_q <= target;
					unset_q <= 1'b0;
				end else begin
					position_q <= moved;
					stamp_q <= now_t;
				end
			end
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ST_CALC) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q <= REM_W'(moved);
			quo_q <= '0;
			res_q <= (sw == SW_DISCONNECTED) ? VAL_ZERO : snap_val;
		end else if (state_q == ST_CALC) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
			if (div_done) begin
				res_q <= VAL_W'(quo_next) - VAL_OFFSET;
			end
		end
		if (load_out) begin
			value_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign value = value_q;

endmodule

FILE: sv/ssr_checker.sv
// Port-level checks for switch_slew_ramp, bound to the top level.
// Uses ssr_pkg for widths.
module ssr_checker
	import ssr_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic signed [VAL_W-1:0] value,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	input logic [DATA_W-1:0] prdata
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(value))
		else $error("response dropped or changed while stalled");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (value >= -10'sd256) && (value <= 10'sd256))
		else $error("value outside -256..256");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in flight");

	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[ADDR_W-1] == REG_RAMP_DURATION
		|=> (paddr[ADDR_W-1] != REG_RAMP_DURATION) ||
			(prdata == {18'b0, $past(pwdata[DUR_W-1:0])}))
		else $error("duration readback mismatch");

endmodule

bind switch_slew_ramp ssr_checker u_ssr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.value(value),
	.psel(psel),
	.penable(penable),
	.pwrite(pwrite),
	.paddr(paddr),
	.pwdata(pwdata),
	.prdata(prdata)
);

FILE: verif/tb_switch_slew_ramp.sv
// Self-checking testbench for switch_slew_ramp: drives switch requests and
// APB writes of ramp_duration, and checks each value against a slew predictor.
// Depends on ssr_pkg and the switch_slew_ramp RTL only.
module tb_switch_slew_ramp
	import ssr_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 300000;

	class ramp_scoreboard;
		logic [DUR_W-1:0] dur;
		logic [DUR_W-1:0] pos;
		bit unset;
		logic [15:0] last;
		logic signed [VAL_W-1:0] pending[$];
		int fails;
		int noted;
		int checked;

		function new();
			dur = '0;
			pos = '0;
			unset = 1'b1;
			last = '0;
			fails = 0;
			noted = 0;
			checked = 0;
		endfunction

		function void flag(string what, int want, int got);
			fails++;
			if (fails <= 10)
				$display("%t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
		endfunction

		function void load_duration(logic [DUR_W-1:0] d);
			dur = d;
			unset = 1'b1;
		endfunction

		function void note_request(switch_t sw, logic [15:0] stamp);
			int tgt;
			int p;
			int v;
			logic [15:0] dt;
			logic signed [VAL_W-1:0] want;
			noted++;
			if (sw == SW_DISCONNECTED) begin
				want = VAL_ZERO;
			end else begin
				tgt = (sw == SW_UP) ? int'(dur) : (sw == SW_CENTER) ? int'(dur) / 2 : 0;
				if (dur == 0 || unset) begin
					pos = DUR_W'(tgt);
					unset = 1'b0;
					want = (sw == SW_UP) ? VAL_POS_FULL :
						(sw == SW_CENTER) ? VAL_ZERO : VAL_NEG_FULL;
				end else begin
					dt = stamp - last;
					last = stamp;
					p = int'(pos);
					if (p < tgt) begin
						p += int'(dt);
						if (p > tgt)
							p = tgt;
					end else if (p < tgt + int'(dt)) begin
						p = tgt;
					end else begin
						p -= int'(dt);
					end
					pos = DUR_W'(p);
					v = (int'(pos) * 512) / int'(dur) - 256;
					if (v > 256)
						v = 256;
					if (v < -256)
						v = -256;
					want = VAL_W'(v);
				end
			end
			pending.push_back(want);
		endfunction

		function void check_value(logic signed [VAL_W-1:0] got);
			logic signed [VAL_W-1:0] want;
			checked++;
			if (pending.size() == 0) begin
				flag("unexpected value", 0, int'(got));
				return;
			end
			want = pending.pop_front();
			if (got !== want)
				flag("value", int'(want), int'(got));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [1:0] switch_state = '0;
	logic [15:0] now_ms = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic signed [VAL_W-1:0] value;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	ramp_scoreboard sb = new();
	int tx_idle = 0;
	int rx_idle = 0;
	int rx_hold = 0;
	int cycles = 0;
	int settings = 0;
	logic [15:0] cur_now = '0;

	switch_slew_ramp dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.switch_state(switch_state),
		.now_ms(now_ms),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.value(value),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_switch_slew_ramp NOT OK");
			$finish;
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= rx_idle);
			end
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				sb.check_value(value);
		end
	end

	task automatic send_req(switch_t sw, logic [15:0] stamp);
		bit ok;
		while ($urandom_range(0, 99) < tx_idle) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		switch_state <= sw;
		now_ms <= stamp;
		do begin
			@(posedge clk);
			ok = req_ready;
			if (ok)
				sb.note_request(sw, stamp);
			@(negedge clk);
		end while (!ok);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic write_duration(logic [DUR_W-1:0] d);
		bit ok;
		logic [DATA_W-1:0] rd;
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'(REG_RAMP_DURATION) << 2;
		pwdata <= DATA_W'(d);
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
			ok = pready;
			@(negedge clk);
		end while (!ok);
		sb.load_duration(d);
		settings++;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
			ok = pready;
			rd = prdata;
			@(negedge clk);
		end while (!ok);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd[DUR_W-1:0] !== d)
			sb.flag("ramp_duration readback", int'(d), int'(rd[DUR_W-1:0]));
	endtask

	task automatic run_random(int n, int hold_at, int pause_at);
		int run_left;
		int step_max;
		switch_t sw;
		switch_t sw_run;
		logic [15:0] stamp;
		run_left = 0;
		sw_run = SW_UP;
		for (int i = 0; i < n; i++) begin
			if (i == hold_at)
				rx_hold = 300;
			if (i == pause_at)
				drain();
			step_max = (sb.dur < 16) ? 4 : int'(sb.dur) / 8;
			if ($urandom_range(0, 99) < 12) begin
				sw = switch_t'($urandom_range(0, 3));
				stamp = 16'($urandom);
			end else begin
				if (run_left == 0) begin
					run_left = $urandom_range(1, 12);
					sw_run = ($urandom_range(0, 99) < 6) ? SW_DISCONNECTED :
						switch_t'($urandom_range(1, 3));
				end
				run_left--;
				sw = sw_run;
				stamp = cur_now + 16'($urandom_range(0, step_max));
			end
			cur_now = stamp;
			send_req(sw, stamp);
		end
	endtask

	initial begin
		int durs[9];
		durs = '{10000, 16383, 1, 0, 500, 0, 3, 2047, 10000};
		durs[5] = $urandom_range(2, 16383);
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle = 7;
		rx_idle = 69;
		send_req(SW_UP, 16'h0000);
		send_req(SW_CENTER, 16'hFFFF);
		send_req(SW_DOWN, 16'h0005);
		send_req(SW_DISCONNECTED, 16'h8000);
		write_duration(14'd1000);
		send_req(SW_DISCONNECTED, 16'h0040);
		send_req(SW_UP, 16'd100);
		send_req(SW_DOWN, 16'd300);
		send_req(SW_DOWN, 16'd400);
		send_req(SW_CENTER, 16'd5400);
		send_req(SW_UP, 16'd5500);
		send_req(SW_UP, 16'hFFFF);
		send_req(SW_UP, 16'd10);
		send_req(SW_DOWN, 16'd10);
		send_req(SW_DOWN, 16'd20);
		send_req(SW_DOWN, 16'h7FFF);
		send_req(SW_CENTER, 16'h80F9);
		send_req(SW_CENTER, 16'h8200);
		send_req(SW_DISCONNECTED, 16'h5555);
		write_duration(14'd1);
		send_req(SW_UP, 16'd3);
		send_req(SW_CENTER, 16'hAAAA);
		send_req(SW_UP, 16'hAAAA);
		write_duration(14'd16383);
		send_req(SW_DOWN, 16'h0000);
		send_req(SW_UP, 16'hFFFF);
		send_req(SW_UP, 16'h3FFF);

		for (int ph = 0; ph < 9; ph++) begin
			tx_idle = (ph < 3) ? 7 : (ph < 6) ? 69 : 0;
			rx_idle = (ph < 3) ? 69 : (ph < 6) ? 7 : 0;
			write_duration(DUR_W'(durs[ph]));
			run_random(100, (ph == 1) ? 40 : -1, (ph == 4) ? 50 : -1);
		end

		drain();
		repeat (30) @(negedge clk);
		if (sb.pending.size() != 0)
			sb.flag("results outstanding", 0, sb.pending.size());
		$display("covered %0d switch requests and %0d ramp_duration settings",
			sb.noted, settings);
		$display("%0d values checked, %0d failures", sb.checked, sb.fails);
		if (sb.fails == 0) begin
			$display("tb_switch_slew_ramp OK");
		end else begin
			$display("tb_switch_slew_ramp NOT OK");
		end
		$finish;
	end
endmodule

FILE: files.f
sv/ssr_pkg.sv
sv/switch_slew_ramp.sv
sv/ssr_checker.sv
verif/tb_switch_slew_ramp.sv
